>>> rtl/seven_segment_display_register_builder_core_defines.svh
// Assertion macros for the seven-segment register builder.
`ifndef SEVEN_SEGMENT_DISPLAY_REGISTER_BUILDER_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_DISPLAY_REGISTER_BUILDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, idle during reset.
`define SSDRB_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("seven-segment builder: implication check failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define SSDRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("seven-segment builder: next-cycle check failed");

`else

`define SSDRB_ASSERT_IMPLIES(label, ante, cons)
`define SSDRB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/ssdrb_pkg.sv
// Types, codes and glyph conversion for the seven-segment register builder.
package ssdrb_pkg;

    localparam int NUM_REGISTERS = 16;
    localparam int GLYPH_COUNT   = 40;

    // Command codes
    localparam logic [1:0] CMD_RAW  = 2'd0;
    localparam logic [1:0] CMD_HEX  = 2'd1;
    localparam logic [1:0] CMD_CHAR = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] digit_value;
        logic [3:0] position;
        logic       batch_end;
    } ssdrb_in_t;

    typedef struct packed {
        logic [3:0] register_address;
        logic [7:0] register_data;
        logic       last;
    } ssdrb_out_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WRITE = 3'b010,
        ST_EMIT  = 3'b100
    } ssdrb_state_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] idx;
    } glyph_sel_t;

    // Segment patterns, bit 0 is segment a
    localparam logic [7:0] GLYPH [GLYPH_COUNT] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F, 8'h3D, 8'h74, 8'h76,
        8'h05, 8'h06, 8'h0D, 8'h30, 8'h38, 8'h54, 8'h37, 8'h5C, 8'h3F, 8'h73,
        8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h3E, 8'h66, 8'h08, 8'h40, 8'h01
    };

    // Map hex letters A..F / a..f to glyphs 10..15
    function automatic glyph_sel_t hex_letter(input logic [6:0] c);
        glyph_sel_t s;
        s.hit = 1'b1;
        s.idx = '0;
        case (c) inside
            [7'h41:7'h46]: s.idx = 6'(c - 7'h41 + 7'd10);
            [7'h61:7'h66]: s.idx = 6'(c - 7'h61 + 7'd10);
            default:       s.hit = 1'b0;
        endcase
        return s;
    endfunction

    // Glyph index of an ASCII character
    function automatic glyph_sel_t char_index(input logic [6:0] c);
        glyph_sel_t s;
        s.hit = 1'b1;
        s.idx = '0;
        case (c) inside
            [7'h30:7'h39]:  s.idx = 6'(c - 7'h30);
            [7'h41:7'h46],
            [7'h61:7'h66]:  s = hex_letter(c);
            7'h67:          s.idx = 6'h10;   // g
            7'h47:          s.idx = 6'h11;   // G
            7'h68:          s.idx = 6'h12;   // h
            7'h48:          s.idx = 6'h13;   // H
            7'h69:          s.idx = 6'h14;   // i
            7'h49:          s.idx = 6'h15;   // I
            7'h6A, 7'h4A:   s.idx = 6'h16;   // j J
            7'h6C:          s.idx = 6'h17;   // l
            7'h4C:          s.idx = 6'h18;   // L
            7'h6E:          s.idx = 6'h19;   // n
            7'h4E:          s.idx = 6'h1A;   // N
            7'h6F:          s.idx = 6'h1B;   // o
            7'h4F:          s.idx = 6'h1C;   // O
            7'h70, 7'h50:   s.idx = 6'h1D;   // p P
            7'h71, 7'h51:   s.idx = 6'h1E;   // q Q
            7'h72, 7'h52:   s.idx = 6'h1F;   // r R
            7'h73, 7'h53:   s.idx = 6'h20;   // s S
            7'h74, 7'h54:   s.idx = 6'h21;   // t T
            7'h75:          s.idx = 6'h22;   // u
            7'h55:          s.idx = 6'h23;   // U
            7'h79, 7'h59:   s.idx = 6'h24;   // y Y
            7'h5F:          s.idx = 6'h25;   // underscore
            7'h2D:          s.idx = 6'h26;   // minus
            7'h7E:          s.idx = 6'h27;   // overscore
            default:        s.hit = 1'b0;
        endcase
        return s;
    endfunction

    // Segment byte for one digit; unknown codes give a blank without point
    function automatic logic [7:0] seg_convert(input logic [1:0] cmd, input logic [7:0] v);
        glyph_sel_t s;
        logic [7:0] seg;
        s.hit = 1'b0;
        s.idx = '0;
        seg   = '0;
        case (cmd)
            CMD_RAW:
            begin
                seg = v;
            end
            CMD_HEX:
            begin
                if (v[6:4] == 3'd0)
                begin
                    s.hit = 1'b1;
                    s.idx = {2'b00, v[3:0]};
                end
                else
                begin
                    s = hex_letter(v[6:0]);
                end
            end
            CMD_CHAR:
            begin
                s = char_index(v[6:0]);
            end
            default:
            begin
                seg = '0;
            end
        endcase
        if (s.hit)
        begin
            seg = GLYPH[s.idx] | {v[7], 7'b0};
        end
        return seg;
    endfunction

endpackage

>>> rtl/seven_segment_display_register_builder_core.sv
// Seven-segment display register builder: digit conversion and anode shadow sequencer.
//
//   channel   signals                          direction  transfer when
//   in        in_valid, in_ready, in_data      sink       in_valid && in_ready
//   out       out_valid, out_ready, out_data   source     out_valid && out_ready
//   cfg       cfg_write_en, cfg_write_data     sink       cfg_write_en
//
// Common-cathode digit: converted combinationally, result sits in the output register.
// Common-anode digit: one shadow bit per cycle through a single bit-insert path;
// batch end then emits all 16 shadow registers, one per cycle while the output is
// free, through the one read port of the shadow.
// Reset clears the shadow, mode register, sequencer and output valid at once.
// A stalled output holds its transfer; the emit sweep waits on it and the input stays blocked.
`include "seven_segment_display_register_builder_core_defines.svh"

module seven_segment_display_register_builder_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ssdrb_pkg::ssdrb_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ssdrb_pkg::ssdrb_out_t out_data,
    input  logic                  cfg_write_en,
    input  logic                  cfg_write_data
);
    import ssdrb_pkg::*;

    ssdrb_state_t state_reg, state_next;
    logic         common_anode_reg;
    logic [2:0]   bit_cnt_reg;
    logic [3:0]   emit_cnt_reg;
    logic         out_valid_reg;
    ssdrb_out_t   out_data_reg;
    logic [7:0]   seg_reg;
    logic [3:0]   pos_reg;
    logic         end_reg;
    logic [7:0]   shadow_reg [NUM_REGISTERS];

    logic         out_free;
    logic         in_xfer;
    logic         cmd_known;
    logic [7:0]   seg_conv;
    logic [3:0]   wr_row;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_xfer   = in_valid && in_ready;
    assign cmd_known = (in_data.command != CMD_NONE);
    assign seg_conv  = seg_convert(in_data.command, in_data.digit_value);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Shadow row for the current bit: 2k for low digits, 2k+1 for high digits
    assign wr_row = {bit_cnt_reg, pos_reg[3]};

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && cmd_known && common_anode_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (&bit_cnt_reg)
                begin
                    state_next = end_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free && (&emit_cnt_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, mode register and shadow store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            common_anode_reg <= 1'b0;
            bit_cnt_reg      <= '0;
            emit_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_REGISTERS; i++)
            begin
                shadow_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                common_anode_reg <= cfg_write_data;
            end

            // Load a new result, else drop the output once it is taken
            if (((state_reg == ST_IDLE) && in_xfer && cmd_known && !common_anode_reg)
                || ((state_reg == ST_EMIT) && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == ST_IDLE)
            begin
                bit_cnt_reg  <= '0;
                emit_cnt_reg <= '0;
            end

            // Insert one segment bit per cycle into its shadow column
            if (state_reg == ST_WRITE)
            begin
                shadow_reg[wr_row][pos_reg[2:0]] <= seg_reg[bit_cnt_reg];
                bit_cnt_reg <= bit_cnt_reg + 3'd1;
            end

            // Emit one shadow register per free output slot
            if ((state_reg == ST_EMIT) && out_free)
            begin
                emit_cnt_reg  <= emit_cnt_reg + 4'd1;
            end
        end
    end

    // Hold digit payload and load results
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            seg_reg <= seg_conv;
            pos_reg <= in_data.position;
            end_reg <= in_data.batch_end;
            if (cmd_known && !common_anode_reg)
            begin
                out_data_reg.register_address <= in_data.position;
                out_data_reg.register_data    <= seg_conv;
                out_data_reg.last             <= 1'b1;
            end
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_data_reg.register_address <= emit_cnt_reg;
            out_data_reg.register_data    <= shadow_reg[emit_cnt_reg];
            out_data_reg.last             <= &emit_cnt_reg;
        end
    end

    // Only the anode sweep produces results that are not last
    `SSDRB_ASSERT_IMPLIES(a_nonlast_from_anode, out_valid && !out_data.last, common_anode_reg)
    // The bit-insert pass ends after eight steps
    `SSDRB_ASSERT_NEXT(a_write_ends, (state_reg == ST_WRITE) && (&bit_cnt_reg), state_reg != ST_WRITE)
    // A last anode result always carries the top register address
    `SSDRB_ASSERT_IMPLIES(a_sweep_last_addr, out_valid && out_data.last && common_anode_reg, out_data.register_address == 4'hF)

endmodule
